FILE: rtl/box_blur_5x5_edge_clipped_defines.svh
// Assertion macros shared by the blur block.
`ifndef BOX_BLUR_5X5_EDGE_CLIPPED_DEFINES_SVH
`define BOX_BLUR_5X5_EDGE_CLIPPED_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BB5_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BB5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BB5_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BB5_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bb5_pkg.sv
`default_nettype none

package bb5_pkg;

	// Default build parameters.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_RADIUS    = 2;

	// Configuration register map and reset values.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int W_CFG_W    = 11;
	localparam int H_CFG_W    = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
	localparam logic [W_CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [H_CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	// Request kinds.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_of_frame;
	} res_item_t;

endpackage

`default_nettype wire

FILE: rtl/bb5_ram.sv
`default_nettype none

module bb5_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bb5_div.sv
`default_nettype none

module bb5_div #(
	parameter int SUM_W = 13,
	parameter int CNT_W = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2:0][SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0]      divisor,
	output logic                       done,
	output logic      [2:0][7:0]       quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [2:0][SUM_W-1:0] quo_q;
	logic [2:0][CNT_W-1:0] rem_q;
	logic [CNT_W-1:0]      div_q;
	logic [STEP_W-1:0]     step_q;
	logic                  run_q;
	logic                  done_q;

	logic [2:0][SUM_W-1:0] quo_nx;
	logic [2:0][CNT_W-1:0] rem_nx;

	// One restoring step per cycle in each of the three color lanes.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [CNT_W:0] trial;
			trial = {rem_q[i], quo_q[i][SUM_W-1]};
			if (trial >= {1'b0, div_q}) begin
				rem_nx[i] = CNT_W'(trial - {1'b0, div_q});
				quo_nx[i] = {quo_q[i][SUM_W-2:0], 1'b1};
			end else begin
				rem_nx[i] = trial[CNT_W-1:0];
				quo_nx[i] = {quo_q[i][SUM_W-2:0], 1'b0};
			end
		end
	end

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Lane data.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;

	// A window mean never exceeds one byte.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quotient[i] = quo_q[i][7:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/box_blur_5x5_edge_clipped.sv
// Box blur over a (2*RADIUS+1) square window, clipped at the frame edges, for an
// RGB888 raster stream. Each output is the truncated mean of the window pixels
// that lie inside the frame. Output k follows input transaction k+RADIUS*W+RADIUS;
// after the frame, RADIUS*W+RADIUS flush transactions drain the rest, and the
// final output carries last_of_frame. A flush with no frame in progress is
// dropped. Pixels live in one line store of 3*RADIUS+1 rows with a single read
// port, and the means come from a bit-serial divider, so the block takes one
// transaction at a time and stalls the input until it is through with it. The
// window is read one position per cycle and the divider yields one quotient
// bit per cycle. Writing a configuration register restarts the frame; the
// line store needs no clearing after reset.
`default_nettype none
`include "box_blur_5x5_edge_clipped_defines.svh"

module box_blur_5x5_edge_clipped #(
	parameter int MAX_WIDTH = bb5_pkg::DEF_MAX_WIDTH,
	parameter int RADIUS    = bb5_pkg::DEF_RADIUS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_stall,
	input  wire bb5_pkg::pix_item_t              pix_data,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output bb5_pkg::res_item_t                   res_data,
	input  wire logic                            cfg_wr_en,
	input  wire logic [bb5_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bb5_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int N     = 2 * RADIUS + 1;
	// Narrow frames run the input up to 2*RADIUS rows ahead of the output row.
	localparam int NS    = 3 * RADIUS + 1;
	localparam int SW    = $clog2(NS);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int EW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = bb5_pkg::H_CFG_W;
	localparam int ROW_W = HW + 1;
	localparam int IDX_W = EW + HW + 1;
	localparam int SUM_W = $clog2(N * N * 255 + 1);
	localparam int CNT_W = $clog2(N * N + 1);
	localparam int AW    = SW + CW;
	localparam int DEPTH = NS * (2 ** CW);
	localparam int YW    = ROW_W + 2;
	localparam int XW    = CW + 2;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_WRITE = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_START = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [bb5_pkg::W_CFG_W-1:0] cfg_w_q;
	logic [HW-1:0]               cfg_h_q;
	logic [EW-1:0]               eff_w;
	logic [HW-1:0]               eff_h;
	logic [IDX_W-1:0]            total_q;
	logic [IDX_W-1:0]            lead_q;

	bb5_pkg::pix_item_t item_q;
	logic [IDX_W-1:0]   in_idx_q;
	logic [CW-1:0]      in_col_q;
	logic [SW-1:0]      in_slot_q;
	logic [CW-1:0]      out_col_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [SW-1:0]      out_slot_q;

	logic [SW-1:0]         wy_q;
	logic [SW-1:0]         wx_q;
	logic [SW-1:0]         rd_slot_q;
	logic                  rd_pend_s1;
	logic [CNT_W-1:0]      cnt_q;
	logic [2:0][SUM_W-1:0] sum_q;

	logic                 res_valid_q;
	bb5_pkg::res_item_t   res_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [23:0]          rd_data;
	logic                 div_start;
	logic                 div_done;
	logic [2:0][7:0]      div_quo;
	logic signed [YW-1:0] yy;
	logic signed [XW-1:0] xx;
	logic                 pos_ok;
	logic                 out_last;
	logic                 res_load;
	logic                 pix_accept;
	logic [SW:0]          slot_base;

	// Effective frame size after range clipping.
	always_comb begin
		logic [31:0] w_ext;
		w_ext = 32'(cfg_w_q);
		if (w_ext == 32'd0) begin
			eff_w = EW'(1);
		end else if (w_ext > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(w_ext);
		end
		eff_h = (cfg_h_q == '0) ? HW'(1) : cfg_h_q;
	end

	// Frame pixel count and output lead, refreshed every cycle.
	always_ff @(posedge clk) begin
		total_q <= IDX_W'(eff_w) * IDX_W'(eff_h);
		lead_q  <= IDX_W'(RADIUS) * IDX_W'(eff_w) + IDX_W'(RADIUS);
	end

	// Current window position relative to the output pixel.
	always_comb begin
		yy = $signed(YW'(out_row_q)) + $signed(YW'(wy_q)) - $signed(YW'(RADIUS));
		xx = $signed(XW'(out_col_q)) + $signed(XW'(wx_q)) - $signed(XW'(RADIUS));
		pos_ok = !yy[YW-1] && (yy < $signed(YW'(eff_h))) &&
			!xx[XW-1] && (xx < $signed(XW'(eff_w)));
	end

	assign slot_base  = (SW + 1)'(out_slot_q) + (SW + 1)'(NS - RADIUS);
	assign pix_stall  = (state_q != ST_IDLE);
	assign pix_accept = pix_valid && !pix_stall;
	assign wr_en      = (state_q == ST_WRITE) && (in_idx_q < total_q);
	assign wr_addr    = {in_slot_q, in_col_q};
	assign rd_en      = (state_q == ST_READ) && pos_ok;
	assign rd_addr    = {rd_slot_q, xx[CW-1:0]};
	assign div_start  = (state_q == ST_START);
	assign out_last   = (out_row_q == ROW_W'(eff_h - 1'b1)) &&
		(EW'(out_col_q) == eff_w - 1'b1);
	assign res_load   = (state_q == ST_OUT) && (!res_valid_q || !res_stall);

	bb5_ram #(
		.WIDTH (24),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({item_q.red_in, item_q.green_in, item_q.blue_in}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bb5_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Captured transaction payload.
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			item_q <= pix_data;
		end
	end

	// Sequencer, position counters and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_w_q    <= bb5_pkg::RST_FRAME_WIDTH;
			cfg_h_q    <= bb5_pkg::RST_FRAME_HEIGHT;
			in_idx_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			wy_q       <= '0;
			wx_q       <= '0;
			rd_slot_q  <= '0;
			rd_pend_s1 <= 1'b0;
			cnt_q      <= '0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (cfg_wr_en) begin
				if (cfg_index == bb5_pkg::CFG_FRAME_WIDTH) begin
					cfg_w_q <= cfg_data[bb5_pkg::W_CFG_W-1:0];
				end else begin
					cfg_h_q <= cfg_data;
				end
				in_idx_q   <= '0;
				in_col_q   <= '0;
				in_slot_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						// A flush with no frame in progress is dropped.
						if (pix_accept && !(pix_data.req_type == bb5_pkg::REQ_FLUSH &&
							in_idx_q == '0)) begin
							state_q <= ST_WRITE;
						end
					end
					ST_WRITE: begin
						in_idx_q <= in_idx_q + 1'b1;
						if (EW'(in_col_q) == eff_w - 1'b1) begin
							in_col_q  <= '0;
							in_slot_q <= (in_slot_q == SW'(NS - 1)) ? '0 : in_slot_q + 1'b1;
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
						if (in_idx_q >= lead_q) begin
							state_q   <= ST_READ;
							wy_q      <= '0;
							wx_q      <= '0;
							cnt_q     <= '0;
							rd_slot_q <= (slot_base >= (SW + 1)'(NS)) ?
								SW'(slot_base - (SW + 1)'(NS)) : SW'(slot_base);
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_READ: begin
						// Walk the window row by row, one position per cycle.
						if (rd_en) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (wx_q == SW'(N - 1)) begin
							wx_q      <= '0;
							wy_q      <= wy_q + 1'b1;
							rd_slot_q <= (rd_slot_q == SW'(NS - 1)) ? '0 : rd_slot_q + 1'b1;
							if (wy_q == SW'(N - 1)) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							wx_q <= wx_q + 1'b1;
						end
					end
					ST_DRAIN: begin
						state_q <= ST_START;
					end
					ST_START: begin
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						if (div_done) begin
							state_q <= ST_OUT;
						end
					end
					ST_OUT: begin
						if (res_load) begin
							state_q <= ST_IDLE;
							if (out_last) begin
								in_idx_q   <= '0;
								in_col_q   <= '0;
								in_slot_q  <= '0;
								out_col_q  <= '0;
								out_row_q  <= '0;
								out_slot_q <= '0;
							end else if (EW'(out_col_q) == eff_w - 1'b1) begin
								out_col_q  <= '0;
								out_row_q  <= out_row_q + 1'b1;
								out_slot_q <= (out_slot_q == SW'(NS - 1)) ? '0 :
									out_slot_q + 1'b1;
							end else begin
								out_col_q <= out_col_q + 1'b1;
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Window sums, one pixel per cycle as read data returns.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			sum_q <= '0;
		end else if (rd_pend_s1) begin
			sum_q[2] <= sum_q[2] + SUM_W'(rd_data[23:16]);
			sum_q[1] <= sum_q[1] + SUM_W'(rd_data[15:8]);
			sum_q[0] <= sum_q[0] + SUM_W'(rd_data[7:0]);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.red_out       <= div_quo[2];
			res_q.green_out     <= div_quo[1];
			res_q.blue_out      <= div_quo[0];
			res_q.last_of_frame <= out_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Reads and writes of the line store never share a cycle.
	`BB5_ASSERT_SAME(a_rd_wr_apart, clk, arst_n, rd_en, !wr_en)
	// Returning read data only arrives while the window is being summed.
	`BB5_ASSERT_SAME(a_pend_window, clk, arst_n, rd_pend_s1,
		state_q == ST_READ || state_q == ST_DRAIN)
	// The divider finishes only while the sequencer waits for it.
	`BB5_ASSERT_SAME(a_div_done, clk, arst_n, div_done, state_q == ST_DIV)
	// The window always holds its center pixel.
	`BB5_ASSERT_SAME(a_cnt_nonzero, clk, arst_n, div_start, cnt_q != '0)
	// A loaded result is shown in the next cycle.
	`BB5_ASSERT_NEXT(a_res_shown, clk, arst_n, res_load, res_valid)

endmodule

`default_nettype wire
